### src/ordered_list_store_defines.svh
// Assertion macros used by the top module to check its own logic.
`ifndef ORDERED_LIST_STORE_DEFINES_SVH
`define ORDERED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ordered list store check failed");

// Next-cycle implication, checked outside reset.
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ordered list store check failed");

`endif

### src/olst_pkg.sv
`default_nettype none

package olst_pkg;

    // Storage shape.
    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths of the words on the ports.
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int HIT_W  = 6;
    localparam int ECNT_W = 7;
    localparam int ST_W   = 2;

    // Width used to compare positions against cell indexes and the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_EDIT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_GET    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIND   = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                  exec;
        logic [ACT_W-1:0]      action;
        logic [CMP_W-1:0]      pos;
        logic [CMP_W-1:0]      count;
        logic [WORD_WIDTH-1:0] data;
    } cmd_t;

endpackage

`default_nettype wire

### src/ordered_list_store.sv
// Channel | Ports                          | Word layout (low bit first)
// s_      | s_tvalid s_tready s_tdata[47:0]| action[2:0] position[9:3] data_word[41:10]
// m_      | m_tvalid m_tready m_tdata[47:0]| read_word[31:0] hit_position[37:32]
//         |                                | entry_count[44:38] status[46:45]
//
// A request is accepted, executed in the cell chain, and then has the find
// position encoded into the output register.
// The single controller accepts no new request until it has walked the
// current one through those steps.
// A result waiting in the output register does not block the next accept; the
// controller stalls only when a second result is ready and the first is untaken.
// Reset (aresetn low, synchronous) empties the list; no clearing pass is needed.
`default_nettype none
`include "ordered_list_store_defines.svh"

module ordered_list_store (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], position[9:3], data_word[41:10], zero fill[47:42]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_word[31:0], hit_position[37:32], entry_count[44:38], status[46:45], zero[47]
    output logic      [47:0] m_tdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Request registers.
    logic [olst_pkg::ACT_W-1:0]  act_reg;
    logic [olst_pkg::POS_W-1:0]  pos_reg;
    logic [olst_pkg::DATA_W-1:0] data_reg;

    logic [olst_pkg::CNT_W-1:0] count_reg;
    logic [olst_pkg::CNT_W-1:0] count_next;

    // Execute-stage results.
    logic [olst_pkg::ST_W-1:0]   status_reg;
    logic [olst_pkg::ST_W-1:0]   status_next;
    logic [olst_pkg::DATA_W-1:0] rd_reg;
    logic [olst_pkg::DATA_W-1:0] rd_next;
    logic [olst_pkg::DEPTH-1:0]  match_reg;
    logic                        find_reg;

    // Output register.
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    olst_pkg::cmd_t                  cmd;
    logic [olst_pkg::DEPTH-1:0]      match_vec;
    logic [olst_pkg::WORD_WIDTH-1:0] chain_word;
    logic                            full;
    logic                            pos_past_end;
    logic                            pos_not_below;
    logic                            modify_ok;
    logic                            s_fire;
    logic                            out_free;
    logic [olst_pkg::IDX_W-1:0]      hit_idx;
    logic [olst_pkg::HIT_W-1:0]      hit_pos;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Range and capacity checks against the count before this request.
    assign full          = (count_reg == olst_pkg::CNT_W'(olst_pkg::DEPTH));
    assign pos_past_end  = (olst_pkg::CMP_W'(pos_reg) > olst_pkg::CMP_W'(count_reg));
    assign pos_not_below = (olst_pkg::CMP_W'(pos_reg) >= olst_pkg::CMP_W'(count_reg));

    always_comb begin
        status_next = olst_pkg::ST_OK;
        modify_ok   = 1'b0;
        count_next  = count_reg;
        rd_next     = '0;
        unique case (act_reg)
            olst_pkg::ACT_APPEND: begin
                if (full) begin
                    status_next = olst_pkg::ST_FULL;
                end else begin
                    modify_ok  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            olst_pkg::ACT_INSERT: begin
                if (full) begin
                    status_next = olst_pkg::ST_FULL;
                end else if (pos_past_end) begin
                    status_next = olst_pkg::ST_RANGE;
                end else begin
                    modify_ok  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            olst_pkg::ACT_EDIT: begin
                if (pos_not_below) status_next = olst_pkg::ST_RANGE;
                else modify_ok = 1'b1;
            end
            olst_pkg::ACT_REMOVE: begin
                if (pos_not_below) begin
                    status_next = olst_pkg::ST_RANGE;
                end else begin
                    modify_ok  = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            olst_pkg::ACT_GET: begin
                if (pos_not_below) begin
                    status_next = olst_pkg::ST_RANGE;
                end else begin
                    rd_next = olst_pkg::DATA_W'(signed'(chain_word));
                end
            end
            olst_pkg::ACT_FIND: begin
                status_next = (|match_vec) ? olst_pkg::ST_OK : olst_pkg::ST_MISS;
            end
            default: begin
                status_next = olst_pkg::ST_OK;
            end
        endcase
    end

    // Command to the cells, valid only in the execute cycle.
    always_comb begin
        cmd.exec   = (state_reg == S_EXEC) && modify_ok;
        cmd.action = act_reg;
        cmd.pos    = olst_pkg::CMP_W'(pos_reg);
        cmd.count  = olst_pkg::CMP_W'(count_reg);
        cmd.data   = olst_pkg::WORD_WIDTH'(signed'(data_reg));
    end

    olst_chain u_chain (
        .aclk      (aclk),
        .cmd       (cmd),
        .match_vec (match_vec),
        .read_word (chain_word)
    );

    // Lowest matching cell wins.
    always_comb begin
        hit_idx = '0;
        for (int k = olst_pkg::DEPTH - 1; k >= 0; k--) begin
            if (match_reg[k]) hit_idx = olst_pkg::IDX_W'(k);
        end
        hit_pos = (find_reg && (status_reg == olst_pkg::ST_OK))
                  ? olst_pkg::HIT_W'(hit_idx) : '0;
    end

    // Controller sequence.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EXEC) begin
                count_reg <= count_next;
            end
            if ((state_reg == S_DONE) && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg  <= s_tdata[2:0];
            pos_reg  <= s_tdata[9:3];
            data_reg <= s_tdata[41:10];
        end
        if (state_reg == S_EXEC) begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
            match_reg  <= match_vec;
            find_reg   <= (act_reg == olst_pkg::ACT_FIND);
        end
        if ((state_reg == S_DONE) && out_free) begin
            out_data_reg <= {1'b0, status_reg, olst_pkg::ECNT_W'(count_reg), hit_pos, rd_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Internal checks.
    `OLST_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1,
                      count_reg <= olst_pkg::CNT_W'(olst_pkg::DEPTH))
    `OLST_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_fire, state_reg == S_EXEC)
    `OLST_ASSERT_NEXT(a_count_hold, aclk, aresetn, state_reg != S_EXEC, $stable(count_reg))

endmodule

`default_nettype wire

### src/olst_cell.sv
`default_nettype none

module olst_cell (
    input  wire logic                           aclk,
    input  wire logic [olst_pkg::CMP_W-1:0]     cell_index,
    input  wire olst_pkg::cmd_t                 cmd,
    input  wire logic [olst_pkg::WORD_WIDTH-1:0] left_word,
    input  wire logic [olst_pkg::WORD_WIDTH-1:0] right_word,
    output logic      [olst_pkg::WORD_WIDTH-1:0] word,
    output logic                                match,
    output logic      [olst_pkg::WORD_WIDTH-1:0] sel_word
);

    logic [olst_pkg::WORD_WIDTH-1:0] word_reg;
    logic [olst_pkg::WORD_WIDTH-1:0] word_next;
    logic                            at_pos;
    logic                            above_pos;
    logic                            occupied;

    assign at_pos    = (cell_index == cmd.pos);
    assign above_pos = (cell_index > cmd.pos);
    assign occupied  = (cell_index < cmd.count);

    // Each cell decides from its own index whether it loads, shifts or holds.
    always_comb begin
        word_next = word_reg;
        if (cmd.exec) begin
            unique case (cmd.action)
                olst_pkg::ACT_APPEND: begin
                    if (cell_index == cmd.count) word_next = cmd.data;
                end
                olst_pkg::ACT_INSERT: begin
                    if (at_pos) word_next = cmd.data;
                    else if (above_pos) word_next = left_word;
                end
                olst_pkg::ACT_EDIT: begin
                    if (at_pos) word_next = cmd.data;
                end
                olst_pkg::ACT_REMOVE: begin
                    if (at_pos || above_pos) word_next = right_word;
                end
                default: begin
                    word_next = word_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // Compare and read taps on the current contents.
    assign word     = word_reg;
    assign match    = occupied && (word_reg == cmd.data);
    assign sel_word = at_pos ? word_reg : '0;

endmodule

`default_nettype wire

### src/olst_chain.sv
`default_nettype none

module olst_chain (
    input  wire logic                            aclk,
    input  wire olst_pkg::cmd_t                  cmd,
    output logic      [olst_pkg::DEPTH-1:0]      match_vec,
    output logic      [olst_pkg::WORD_WIDTH-1:0] read_word
);

    logic [olst_pkg::WORD_WIDTH-1:0] words    [olst_pkg::DEPTH];
    logic [olst_pkg::WORD_WIDTH-1:0] sel_words[olst_pkg::DEPTH];

    // Row of cells; each inner one sees its two neighbors, the first takes the command data on its left.
    for (genvar i = 0; i < olst_pkg::DEPTH; i++) begin : g_cell
        logic [olst_pkg::WORD_WIDTH-1:0] left_w;
        logic [olst_pkg::WORD_WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = cmd.data;
        end else begin : g_inner_l
            assign left_w = words[i-1];
        end

        if (i == olst_pkg::DEPTH - 1) begin : g_last
            assign right_w = words[i];
        end else begin : g_inner_r
            assign right_w = words[i+1];
        end

        olst_cell u_cell (
            .aclk       (aclk),
            .cell_index (olst_pkg::CMP_W'(i)),
            .cmd        (cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .match      (match_vec[i]),
            .sel_word   (sel_words[i])
        );
    end

    // Only the addressed cell drives a nonzero read tap, so an OR collects it.
    always_comb begin
        read_word = '0;
        for (int k = 0; k < olst_pkg::DEPTH; k++) begin
            read_word = read_word | sel_words[k];
        end
    end

endmodule

`default_nettype wire
